/* rtl/ps2a_pkg.sv */
// shared types, constants and key translation tables for the ps/2 set 1 to ascii block
// no dependencies
`timescale 1ns / 1ps

package ps2a_pkg;

    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [6:0] KEY_LSHIFT = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT = 7'h36;
    localparam logic [6:0] KEY_CTRL   = 7'h1D;
    localparam logic [6:0] KEY_CAPS   = 7'h3A;

    typedef struct packed {
        logic       opcode;
        logic [7:0] scancode;
    } in_item_t;

    typedef struct packed {
        logic [6:0] char_out;
        logic       char_valid;
        logic       dropped;
        logic       has_data;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_PUSH,
        CMD_POP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [6:0] ch;
    } cmd_t;

    typedef struct packed {
        logic pop_hit;
        logic dropped;
        logic has_data;
    } back_info_t;

    function automatic logic [6:0] rom_plain(input logic [6:0] key);
        logic [6:0] r;
        case (key)
            7'h01: r = 7'h1B;  7'h02: r = 7'h31;  7'h03: r = 7'h32;  7'h04: r = 7'h33;
            7'h05: r = 7'h34;  7'h06: r = 7'h35;  7'h07: r = 7'h36;  7'h08: r = 7'h37;
            7'h09: r = 7'h38;  7'h0A: r = 7'h39;  7'h0B: r = 7'h30;  7'h0C: r = 7'h2D;
            7'h0D: r = 7'h3D;  7'h0E: r = 7'h08;  7'h0F: r = 7'h09;
            7'h10: r = 7'h71;  7'h11: r = 7'h77;  7'h12: r = 7'h65;  7'h13: r = 7'h72;
            7'h14: r = 7'h74;  7'h15: r = 7'h79;  7'h16: r = 7'h75;  7'h17: r = 7'h69;
            7'h18: r = 7'h6F;  7'h19: r = 7'h70;  7'h1A: r = 7'h5B;  7'h1B: r = 7'h5D;
            7'h1C: r = 7'h0A;  7'h1E: r = 7'h61;  7'h1F: r = 7'h73;
            7'h20: r = 7'h64;  7'h21: r = 7'h66;  7'h22: r = 7'h67;  7'h23: r = 7'h68;
            7'h24: r = 7'h6A;  7'h25: r = 7'h6B;  7'h26: r = 7'h6C;  7'h27: r = 7'h3B;
            7'h28: r = 7'h27;  7'h29: r = 7'h60;  7'h2B: r = 7'h5C;  7'h2C: r = 7'h7A;
            7'h2D: r = 7'h78;  7'h2E: r = 7'h63;  7'h2F: r = 7'h76;
            7'h30: r = 7'h62;  7'h31: r = 7'h6E;  7'h32: r = 7'h6D;  7'h33: r = 7'h2C;
            7'h34: r = 7'h2E;  7'h35: r = 7'h2F;  7'h37: r = 7'h2A;  7'h39: r = 7'h20;
            7'h4A: r = 7'h2D;  7'h4E: r = 7'h2B;
            default: r = 7'h00;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] rom_upper(input logic [6:0] key);
        logic [6:0] r;
        case (key)
            7'h01: r = 7'h1B;  7'h02: r = 7'h21;  7'h03: r = 7'h40;  7'h04: r = 7'h23;
            7'h05: r = 7'h24;  7'h06: r = 7'h25;  7'h07: r = 7'h5E;  7'h08: r = 7'h26;
            7'h09: r = 7'h2A;  7'h0A: r = 7'h28;  7'h0B: r = 7'h29;  7'h0C: r = 7'h5F;
            7'h0D: r = 7'h2B;  7'h0E: r = 7'h08;  7'h0F: r = 7'h09;
            7'h10: r = 7'h51;  7'h11: r = 7'h57;  7'h12: r = 7'h45;  7'h13: r = 7'h52;
            7'h14: r = 7'h54;  7'h15: r = 7'h59;  7'h16: r = 7'h55;  7'h17: r = 7'h49;
            7'h18: r = 7'h4F;  7'h19: r = 7'h50;  7'h1A: r = 7'h7B;  7'h1B: r = 7'h7D;
            7'h1C: r = 7'h0A;  7'h1E: r = 7'h41;  7'h1F: r = 7'h53;
            7'h20: r = 7'h44;  7'h21: r = 7'h46;  7'h22: r = 7'h47;  7'h23: r = 7'h48;
            7'h24: r = 7'h4A;  7'h25: r = 7'h4B;  7'h26: r = 7'h4C;  7'h27: r = 7'h3A;
            7'h28: r = 7'h22;  7'h29: r = 7'h7E;  7'h2B: r = 7'h7C;  7'h2C: r = 7'h5A;
            7'h2D: r = 7'h58;  7'h2E: r = 7'h43;  7'h2F: r = 7'h56;
            7'h30: r = 7'h42;  7'h31: r = 7'h4E;  7'h32: r = 7'h4D;  7'h33: r = 7'h3C;
            7'h34: r = 7'h3E;  7'h35: r = 7'h3F;  7'h37: r = 7'h2A;  7'h39: r = 7'h20;
            7'h4A: r = 7'h2D;  7'h4E: r = 7'h2B;
            default: r = 7'h00;
        endcase
        return r;
    endfunction

endpackage

/* rtl/ps2a_ram.sv */
// generic single write port ram with registered, enabled read
// no dependencies
`timescale 1ns / 1ps

module ps2a_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/ps2a_front.sv */
// front end: tracks shift, ctrl and caps and turns each beat into a queue command
// depends on ps2a_pkg
`timescale 1ns / 1ps

module ps2a_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  logic               in_ready,
    input  ps2a_pkg::in_item_t in_data,
    output ps2a_pkg::cmd_t     cmd
);

    logic shift_reg, shift_next;
    logic ctrl_reg,  ctrl_next;
    logic caps_reg,  caps_next;

    logic [6:0] key;
    logic       rel;
    logic [6:0] ch;

    assign key = in_data.scancode[6:0];
    assign rel = in_data.scancode[7];

    always_comb begin
        shift_next = shift_reg;
        ctrl_next  = ctrl_reg;
        caps_next  = caps_reg;
        cmd.kind   = ps2a_pkg::CMD_NOP;
        cmd.ch     = 7'h00;
        ch         = (shift_reg ^ caps_reg) ? ps2a_pkg::rom_upper(key)
                                            : ps2a_pkg::rom_plain(key);
        if (in_data.opcode == ps2a_pkg::OP_POP) begin
            cmd.kind = ps2a_pkg::CMD_POP;
        end else if (key == ps2a_pkg::KEY_LSHIFT || key == ps2a_pkg::KEY_RSHIFT) begin
            shift_next = !rel;
        end else if (key == ps2a_pkg::KEY_CTRL) begin
            ctrl_next = !rel;
        end else if (key == ps2a_pkg::KEY_CAPS && !rel) begin
            caps_next = !caps_reg;
        end else if (!rel && ch != 7'h00) begin
            cmd.kind = ps2a_pkg::CMD_PUSH;
            // ctrl folds letters onto 1..26
            if (ctrl_reg && ((ch >= 7'h61 && ch <= 7'h7A) || (ch >= 7'h41 && ch <= 7'h5A)))
            begin
                cmd.ch = {2'b00, ch[4:0]};
            end else begin
                cmd.ch = ch;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= 1'b0;
            ctrl_reg  <= 1'b0;
            caps_reg  <= 1'b0;
        end else if (in_valid && in_ready) begin
            shift_reg <= shift_next;
            ctrl_reg  <= ctrl_next;
            caps_reg  <= caps_next;
        end
    end

endmodule

/* rtl/ps2a_cmd_q.sv */
// two entry command queue between front and back
// depends on ps2a_pkg
`timescale 1ns / 1ps

module ps2a_cmd_q (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  ps2a_pkg::cmd_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output ps2a_pkg::cmd_t pop_data
);

    ps2a_pkg::cmd_t entry_reg [2];
    logic       wr_idx_reg, wr_idx_next;
    logic       rd_idx_reg, rd_idx_next;
    logic [1:0] count_reg,  count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_idx_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_idx_next = do_push ? !wr_idx_reg : wr_idx_reg;
        rd_idx_next = do_pop  ? !rd_idx_reg : rd_idx_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_idx_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg <= 1'b0;
            rd_idx_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'd2)
        else $error("command queue count out of range");

    a_idx_agree: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_idx_reg == rd_idx_reg))
        else $error("command queue indexes disagree with count");

endmodule

/* rtl/ps2a_back.sv */
// back end: character ring buffer, pointers and result output register
// depends on ps2a_pkg and ps2a_ram
`timescale 1ns / 1ps

module ps2a_back #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  ps2a_pkg::cmd_t      cmd,
    output logic                m_valid,
    input  logic                m_ready,
    output ps2a_pkg::out_item_t m_data
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_inc, rd_inc;

    logic                 s1_valid_reg;
    ps2a_pkg::back_info_t s1_info_reg, s1_info_next;
    logic                 out_valid_reg;
    ps2a_pkg::out_item_t  out_data_reg;

    logic       advance_out, take, full, empty, ram_we, ram_re;
    logic [6:0] ram_rdata;

    assign advance_out = !out_valid_reg || m_ready;
    assign cmd_ready   = !s1_valid_reg || advance_out;
    assign take        = cmd_valid && cmd_ready;

    assign wr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign full   = (wr_inc == rd_ptr_reg);
    assign empty  = (wr_ptr_reg == rd_ptr_reg);

    always_comb begin
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        s1_info_next = '0;
        if (take) begin
            case (cmd.kind)
                ps2a_pkg::CMD_PUSH: begin
                    if (full) begin
                        s1_info_next.dropped = 1'b1;
                    end else begin
                        ram_we      = 1'b1;
                        wr_ptr_next = wr_inc;
                    end
                end
                ps2a_pkg::CMD_POP: begin
                    if (!empty) begin
                        ram_re               = 1'b1;
                        s1_info_next.pop_hit = 1'b1;
                        rd_ptr_next          = rd_inc;
                    end
                end
                default: begin
                end
            endcase
        end
        s1_info_next.has_data = (wr_ptr_next != rd_ptr_next);
    end

    ps2a_ram #(
        .WIDTH (7),
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (cmd.ch),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd_ready) begin
            s1_info_reg <= s1_info_next;
        end
        if (advance_out) begin
            out_data_reg.char_out   <= s1_info_reg.pop_hit ? ram_rdata : 7'h00;
            out_data_reg.char_valid <= s1_info_reg.pop_hit;
            out_data_reg.dropped    <= s1_info_reg.dropped;
            out_data_reg.has_data   <= s1_info_reg.has_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            if (cmd_ready) begin
                s1_valid_reg <= cmd_valid;
            end
            if (advance_out) begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_ptr_reg <= PTR_LAST && rd_ptr_reg <= PTR_LAST)
        else $error("ring pointer beyond depth");

    a_pop_not_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_data_reg.char_valid && out_data_reg.dropped))
        else $error("beat both popped and dropped");

    a_char_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_data_reg.char_valid) |-> (out_data_reg.char_out == 7'h00))
        else $error("character present without valid");

    a_pop_leaves_space: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && ram_re) |=> !full)
        else $error("ring still full after a pop");

endmodule

/* rtl/ps2_scancode_to_ascii_fifo.sv */
// top level of the ps/2 scancode set 1 to ascii translator with character buffer
// depends on ps2a_pkg, ps2a_front, ps2a_cmd_q, ps2a_back
`timescale 1ns / 1ps

// usage:
//   s_ channel: each beat is either a scancode byte (opcode scan) or a pop request.
//   m_ channel: exactly one result beat per input beat, in order. a scancode beat
//   reports dropped when the buffer was full; a pop beat carries the oldest
//   character with char_valid, or zero when the buffer is empty. has_data tells
//   whether characters remain after that beat.
//   path from input handshake to m_valid: queue entry written at the handshake,
//   ring access with registered ram read, output register.
//   throughput: one beat per cycle while m_ready is high; the ring does one write
//   or one read per beat on its single port pair, so nothing else lowers that rate.
//   the buffer holds FIFO_DEPTH - 1 characters.
//   reset: shift, ctrl and caps cleared, buffer empty; no clearing pass is needed.
//   stall: when m_ready is low the result waits in the output register, the back
//   end fills its one stage, and the two entry queue absorbs two more beats before
//   s_ready drops; beats are never lost or repeated.
module ps2_scancode_to_ascii_fifo #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ps2a_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ps2a_pkg::out_item_t m_data
);

    ps2a_pkg::cmd_t front_cmd;
    ps2a_pkg::cmd_t q_cmd;
    logic           q_valid;
    logic           q_ready;

    ps2a_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_data  (s_data),
        .cmd      (front_cmd)
    );

    ps2a_cmd_q u_cmd_q (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_valid),
        .push_ready (s_ready),
        .push_data  (front_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_cmd)
    );

    ps2a_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

/* verif/ps2_scancode_to_ascii_fifo_tb.sv */
// self-checking testbench for the ps/2 set 1 to ascii translator with character buffer
// predicts every result beat from its own key maps and ring copy; needs ps2a_pkg and the rtl
`timescale 1ns / 1ps

module ps2_scancode_to_ascii_fifo_tb;

    localparam int HOLD_CYCLES = 120;
    localparam int STALL_LIMIT = 4000;

    class typing_tracker;
        localparam int RING_DEPTH = 256;
        bit                  shift_on;
        bit                  ctrl_on;
        bit                  caps_lock;
        bit [6:0]            ring [RING_DEPTH];
        int                  wr_idx;
        int                  rd_idx;
        bit [6:0]            plain_map [128];
        bit [6:0]            shift_map [128];
        ps2a_pkg::out_item_t result_backlog [$];
        int                  errors;
        int                  results_seen;
        int                  chars_dropped;
        int                  empty_pops;

        function new();
            bit [6:0] same_key [8] = '{7'h01, 7'h0E, 7'h0F, 7'h1C, 7'h37, 7'h39, 7'h4A, 7'h4E};
            bit [6:0] same_chr [8] = '{7'h1B, 7'h08, 7'h09, 7'h0A, 7'h2A, 7'h20, 7'h2D, 7'h2B};
            foreach (plain_map[i]) begin
                plain_map[i] = '0;
                shift_map[i] = '0;
            end
            fill_row(7'h02, "1234567890-=", "!@#$%^&*()_+");
            fill_row(7'h10, "qwertyuiop[]", "QWERTYUIOP{}");
            fill_row(7'h1E, "asdfghjkl;'", "ASDFGHJKL:\"");
            fill_row(7'h2B, "\\zxcvbnm,./", "|ZXCVBNM<>?");
            plain_map[7'h29] = 7'h60;
            shift_map[7'h29] = 7'h7E;
            foreach (same_key[i]) begin
                plain_map[same_key[i]] = same_chr[i];
                shift_map[same_key[i]] = same_chr[i];
            end
        endfunction

        function void fill_row(int base, string lo, string hi);
            for (int i = 0; i < lo.len(); i++) begin
                plain_map[base + i] = 7'(lo[i]);
                shift_map[base + i] = 7'(hi[i]);
            end
        endfunction

        function bit produces(bit [6:0] key);
            return plain_map[key] != 7'h00;
        endfunction

        function void take_beat(ps2a_pkg::in_item_t x);
            ps2a_pkg::out_item_t e;
            bit                  rel;
            bit [6:0]            key;
            bit [6:0]            ch;
            int                  nxt;
            e = '0;
            if (x.opcode == ps2a_pkg::OP_SCAN) begin
                rel = x.scancode[7];
                key = x.scancode[6:0];
                if (key == ps2a_pkg::KEY_LSHIFT || key == ps2a_pkg::KEY_RSHIFT) begin
                    shift_on = !rel;
                end else if (key == ps2a_pkg::KEY_CTRL) begin
                    ctrl_on = !rel;
                end else if (key == ps2a_pkg::KEY_CAPS) begin
                    if (!rel) caps_lock = !caps_lock;
                end else if (!rel) begin
                    ch = (shift_on ^ caps_lock) ? shift_map[key] : plain_map[key];
                    if (ch != 7'h00) begin
                        // ctrl folds letters of either case onto 1..26
                        if (ctrl_on && ch >= "a" && ch <= "z") ch = 7'(ch - "a" + 1);
                        else if (ctrl_on && ch >= "A" && ch <= "Z") ch = 7'(ch - "A" + 1);
                        nxt = (wr_idx + 1) % RING_DEPTH;
                        if (nxt == rd_idx) begin
                            e.dropped = 1'b1;
                            chars_dropped++;
                        end else begin
                            ring[wr_idx] = ch;
                            wr_idx = nxt;
                        end
                    end
                end
            end else if (wr_idx != rd_idx) begin
                e.char_out = ring[rd_idx];
                e.char_valid = 1'b1;
                rd_idx = (rd_idx + 1) % RING_DEPTH;
            end else begin
                empty_pops++;
            end
            e.has_data = (wr_idx != rd_idx);
            result_backlog.push_back(e);
        endfunction

        function void match_result(ps2a_pkg::out_item_t got);
            ps2a_pkg::out_item_t e;
            results_seen++;
            if (result_backlog.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %h", got);
                return;
            end
            e = result_backlog.pop_front();
            if (got.char_out != e.char_out || got.char_valid != e.char_valid
                    || got.dropped != e.dropped || got.has_data != e.has_data) begin
                errors++;
                if (errors <= 10) begin
                    $display({"result %0d: char_out %h/%h char_valid %b/%b ",
                              "dropped %b/%b has_data %b/%b (exp/got)"},
                             results_seen, e.char_out, got.char_out,
                             e.char_valid, got.char_valid,
                             e.dropped, got.dropped, e.has_data, got.has_data);
                end
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    ps2a_pkg::in_item_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    ps2a_pkg::out_item_t m_data;

    typing_tracker sb;
    bit  no_gaps = 1'b0;
    bit  long_hold = 1'b0;
    int  beats_sent = 0;
    int  idle_cycles = 0;

    ps2_scancode_to_ascii_fifo i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic send_item(input logic op, input logic [7:0] code);
        ps2a_pkg::in_item_t x;
        int                 gap;
        x.opcode = op;
        x.scancode = code;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.take_beat(x);
        beats_sent++;
    endtask

    function automatic logic [6:0] pick_key();
        logic [6:0] k;
        do k = 7'($urandom_range(1, 8'h4E)); while (!sb.produces(k));
        return k;
    endfunction

    // one burst of typing: modifiers around a few keys, with pops and stray bytes mixed in
    task automatic type_word();
        logic [6:0] k;
        logic       use_shift;
        logic       use_ctrl;
        no_gaps = ($urandom_range(0, 3) == 0);
        use_shift = ($urandom_range(0, 2) == 0);
        use_ctrl = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 7) == 0) send_item(ps2a_pkg::OP_SCAN, {1'b0, ps2a_pkg::KEY_CAPS});
        if (use_shift) begin
            send_item(ps2a_pkg::OP_SCAN, {1'b0, $urandom_range(0, 1) ? ps2a_pkg::KEY_LSHIFT
                                                                     : ps2a_pkg::KEY_RSHIFT});
        end
        if (use_ctrl) send_item(ps2a_pkg::OP_SCAN, {1'b0, ps2a_pkg::KEY_CTRL});
        repeat ($urandom_range(1, 6)) begin
            k = pick_key();
            send_item(ps2a_pkg::OP_SCAN, {1'b0, k});
            if ($urandom_range(0, 3) != 0) send_item(ps2a_pkg::OP_SCAN, {1'b1, k});
            if ($urandom_range(0, 2) == 0) begin
                send_item(ps2a_pkg::OP_POP, 8'($urandom_range(0, 255)));
            end
        end
        if (use_ctrl) send_item(ps2a_pkg::OP_SCAN, {1'b1, ps2a_pkg::KEY_CTRL});
        if (use_shift) begin
            send_item(ps2a_pkg::OP_SCAN, {1'b1, $urandom_range(0, 1) ? ps2a_pkg::KEY_LSHIFT
                                                                     : ps2a_pkg::KEY_RSHIFT});
        end
        if ($urandom_range(0, 4) == 0) send_item(ps2a_pkg::OP_SCAN, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 3)) send_item(ps2a_pkg::OP_POP, 8'($urandom_range(0, 255)));
    endtask

    // result side: random back-pressure, one long hold on request
    initial begin
        int wait_n;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (long_hold) begin
                long_hold = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                wait_n = no_gaps ? 0 : $urandom_range(0, 8);
                if (wait_n > 0) begin
                    m_ready <= 1'b0;
                    repeat (wait_n) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            sb.match_result(m_data);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("ps2_scancode_to_ascii_fifo regression: fail");
                $finish;
            end
        end
    end

    initial begin
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty pop, modifiers, caps, ctrl, keypad and ignored bytes
        send_item(ps2a_pkg::OP_POP,  8'hFF);
        send_item(ps2a_pkg::OP_SCAN, 8'h00);
        send_item(ps2a_pkg::OP_SCAN, 8'h1E);
        send_item(ps2a_pkg::OP_SCAN, {1'b0, ps2a_pkg::KEY_LSHIFT});
        send_item(ps2a_pkg::OP_SCAN, 8'h1E);
        send_item(ps2a_pkg::OP_SCAN, 8'h02);
        send_item(ps2a_pkg::OP_SCAN, {1'b0, ps2a_pkg::KEY_CAPS});
        send_item(ps2a_pkg::OP_SCAN, 8'h1E);
        send_item(ps2a_pkg::OP_SCAN, {1'b1, ps2a_pkg::KEY_LSHIFT});
        send_item(ps2a_pkg::OP_SCAN, {1'b1, ps2a_pkg::KEY_CAPS});
        send_item(ps2a_pkg::OP_SCAN, 8'h02);
        send_item(ps2a_pkg::OP_SCAN, {1'b0, ps2a_pkg::KEY_CTRL});
        send_item(ps2a_pkg::OP_SCAN, 8'h2E);
        send_item(ps2a_pkg::OP_SCAN, 8'h1C);
        send_item(ps2a_pkg::OP_SCAN, {1'b1, ps2a_pkg::KEY_CTRL});
        send_item(ps2a_pkg::OP_SCAN, {1'b0, ps2a_pkg::KEY_CAPS});
        send_item(ps2a_pkg::OP_SCAN, {1'b0, ps2a_pkg::KEY_RSHIFT});
        send_item(ps2a_pkg::OP_SCAN, 8'h4A);
        send_item(ps2a_pkg::OP_SCAN, {1'b1, ps2a_pkg::KEY_RSHIFT});
        send_item(ps2a_pkg::OP_SCAN, 8'h4E);
        send_item(ps2a_pkg::OP_SCAN, 8'hE0);
        send_item(ps2a_pkg::OP_SCAN, 8'h7F);
        send_item(ps2a_pkg::OP_SCAN, 8'h9E);

        while (beats_sent < 160) type_word();

        // overfill the buffer while the result side is held off, then drain past empty
        no_gaps = 1'b1;
        long_hold = 1'b1;
        repeat (265) send_item(ps2a_pkg::OP_SCAN, {1'b0, pick_key()});
        no_gaps = 1'b0;
        repeat (262) send_item(ps2a_pkg::OP_POP, 8'($urandom_range(0, 255)));

        while (beats_sent < 700) type_word();
        s_valid <= 1'b0;

        while (sb.result_backlog.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        sb.errors += sb.result_backlog.size();

        $display("covered %0d beats: %0d results checked, %0d chars dropped when full, %0d empty pops",
                 beats_sent, sb.results_seen, sb.chars_dropped, sb.empty_pops);
        if (sb.errors == 0) begin
            $display("ps2_scancode_to_ascii_fifo regression: pass");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("ps2_scancode_to_ascii_fifo regression: fail");
        end
        $finish;
    end

endmodule

/* ps2_scancode_to_ascii_fifo.f */
rtl/ps2a_pkg.sv
rtl/ps2a_ram.sv
rtl/ps2a_front.sv
rtl/ps2a_cmd_q.sv
rtl/ps2a_back.sv
rtl/ps2_scancode_to_ascii_fifo.sv
verif/ps2_scancode_to_ascii_fifo_tb.sv
